// File: hw/rtl/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 6;
    localparam int STATUS_W    = 2;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_EX_ROOT,
        ST_EX_LAST,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_PLACE,
        ST_DONE
    } seq_state_t;

    // two's complement compare: a strictly greater than b
    function automatic logic key_greater(input logic [VALUE_W-1:0] a,
                                         input logic [VALUE_W-1:0] b);
        return $signed(a) > $signed(b);
    endfunction

endpackage

// File: hw/rtl/mhpq_store.sv
`timescale 1ns / 1ps

module mhpq_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [mhpq_pkg::VALUE_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [mhpq_pkg::VALUE_W-1:0] rd_data
);
    import mhpq_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// Insert path, from acceptance to m_axis_tvalid: one store read and compare per level,
// then place and output. Extract path: root and last reads, two child reads per level
// over at most log2(CAPACITY) - 1 levels, then place and output.
// Throughput: one transaction at a time, next input accepted in the cycle after the result is
// loaded; results wait in an output register. Reset: synchronous, active low; clears the
// entry count and the handshake state. Store contents are not cleared; ready right after reset.
module max_heap_priority_queue #(
    parameter int CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] max_value, [33:32] status, [39:34] entry_count
);
    import mhpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    seq_state_t state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [VALUE_W-1:0] cand_reg, cand_next;
    logic               cand_gt_reg, cand_gt_next;
    logic               right_ok_reg, right_ok_next;
    logic [VALUE_W-1:0] res_max_reg, res_max_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [39:0]        m_tdata_reg, m_tdata_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    // shared comparator
    logic [VALUE_W-1:0] cmp_a, cmp_b;
    logic               cmp_gt;

    logic [IW-1:0]      n_ext;
    logic [IW-1:0]      left_idx, right_idx, next_left;
    logic [AW-1:0]      parent_idx, grand_idx, best_idx;
    logic [VALUE_W-1:0] best_val;
    logic               right_gt, moved;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    mhpq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign n_ext      = IW'(count_reg);
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign grand_idx  = (parent_idx - AW'(1)) >> 1;

    always_comb begin
        cmp_a = val_reg;
        cmp_b = mem_rdata;
        case (state_reg)
            ST_DN_LEFT: begin
                cmp_a = mem_rdata;
                cmp_b = val_reg;
            end
            ST_DN_RIGHT: begin
                cmp_a = mem_rdata;
                cmp_b = cand_gt_reg ? cand_reg : val_reg;
            end
            default: begin
                cmp_a = val_reg;
                cmp_b = mem_rdata;
            end
        endcase
    end

    assign cmp_gt = key_greater(cmp_a, cmp_b);

    // sift-down choice: the left child wins ties
    assign right_gt = right_ok_reg && cmp_gt;
    assign moved    = right_gt || cand_gt_reg;
    assign best_idx = right_gt ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign best_val = right_gt ? mem_rdata : cand_reg;
    assign next_left = {1'b0, best_idx, 1'b1};

    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        cand_reg       <= cand_next;
        cand_gt_reg    <= cand_gt_next;
        right_ok_reg   <= right_ok_next;
        res_max_reg    <= res_max_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        cand_next       = cand_reg;
        cand_gt_next    = cand_gt_reg;
        right_ok_next   = right_ok_reg;
        res_max_next    = res_max_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_axis_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = val_reg;
        mem_raddr       = '0;
        s_axis_tready   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_axis_tready   = 1'b1;
                res_max_next    = '0;
                res_status_next = STATUS_OK;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser[0] == OP_INSERT) begin
                        if (count_reg == CAP_CNT) begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_DONE;
                        end else begin
                            // hole starts at the first free slot
                            pos_next   = AW'(count_reg);
                            val_next   = s_axis_tdata;
                            count_next = count_reg + CW'(1);
                            mem_raddr  = (AW'(count_reg) - AW'(1)) >> 1;
                            state_next = (count_reg == '0) ? ST_PLACE : ST_UP_CMP;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_DONE;
                        end else begin
                            count_next = count_reg - CW'(1);
                            mem_raddr  = '0;
                            state_next = ST_EX_ROOT;
                        end
                    end
                end
            end
            ST_UP_CMP: begin
                // mem_rdata holds the parent of the hole
                mem_we = 1'b1;
                if (cmp_gt) begin
                    mem_wdata = mem_rdata;
                    pos_next  = parent_idx;
                    mem_raddr = grand_idx;
                    if (parent_idx == '0) begin
                        state_next = ST_PLACE;
                    end
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_EX_ROOT: begin
                res_max_next = mem_rdata;
                mem_raddr    = AW'(count_reg);
                state_next   = ST_EX_LAST;
            end
            ST_EX_LAST: begin
                val_next = mem_rdata;
                pos_next = '0;
                if (count_reg == '0) begin
                    state_next = ST_DONE;
                end else if (count_reg == CW'(1)) begin
                    state_next = ST_PLACE;
                end else begin
                    mem_raddr  = AW'(1);
                    state_next = ST_DN_LEFT;
                end
            end
            ST_DN_LEFT: begin
                cand_next     = mem_rdata;
                cand_gt_next  = cmp_gt;
                right_ok_next = right_idx < n_ext;
                mem_raddr     = right_idx[AW-1:0];
                state_next    = ST_DN_RIGHT;
            end
            ST_DN_RIGHT: begin
                mem_we = 1'b1;
                if (!moved) begin
                    state_next = ST_DONE;
                end else begin
                    mem_wdata = best_val;
                    pos_next  = best_idx;
                    if (next_left < n_ext) begin
                        mem_raddr  = next_left[AW-1:0];
                        state_next = ST_DN_LEFT;
                    end else begin
                        state_next = ST_PLACE;
                    end
                end
            end
            ST_PLACE: begin
                mem_we     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {count_wide[COUNT_OUT_W-1:0], res_status_reg, res_max_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    localparam logic [COUNT_OUT_W-1:0] CAP_OUT = COUNT_OUT_W'(CAPACITY);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_INSERT
         && count_reg != CAP_CNT) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the heap by one");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[33:32] == STATUS_FULL)
        |-> m_axis_tdata[39:34] == CAP_OUT)
        else $error("full status with a count below capacity");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[33:32] != STATUS_OK)
        |-> m_axis_tdata[31:0] == '0)
        else $error("failed transaction carries a nonzero value");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mhpq_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [VALUE_W-1:0]     max_value;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } heap_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = OP_INSERT;
    logic        m_valid;
    logic        m_ready;
    logic [39:0] m_tdata;

    max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // model of the heap contents
    logic signed [VALUE_W-1:0] heap_model [CAPACITY];
    int heap_fill = 0;

    heap_result_t pending_results [$];

    int errors = 0;
    int cycle_count = 0;
    int n_insert = 0, n_extract = 0, n_full = 0, n_empty = 0, n_checked = 0;
    int rx_hold = 0;
    int rx_wait = 0;
    bit no_idle = 1'b0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return 32'($signed($urandom_range(0, 15)) - 8);  // many equal keys
            default: return $urandom;
        endcase
    endfunction

    function automatic heap_result_t heap_apply(input logic op, input logic [31:0] value);
        heap_result_t res;
        int pos, parent, left, right, best;
        logic signed [VALUE_W-1:0] tmp;
        res = '0;
        if (op == OP_INSERT) begin
            if (heap_fill >= CAPACITY) begin
                res.status = STATUS_FULL;
            end else begin
                heap_model[heap_fill] = value;
                pos = heap_fill;
                heap_fill++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (heap_model[pos] <= heap_model[parent]) break;
                    tmp = heap_model[pos];
                    heap_model[pos] = heap_model[parent];
                    heap_model[parent] = tmp;
                    pos = parent;
                end
            end
        end else if (heap_fill == 0) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.max_value = heap_model[0];
            heap_model[0] = heap_model[heap_fill - 1];
            heap_fill--;
            pos = 0;
            // left child wins a tie between equal children
            while (heap_fill > 1) begin
                left = 2 * pos + 1;
                right = left + 1;
                best = pos;
                if (left < heap_fill && heap_model[left] > heap_model[best]) best = left;
                if (right < heap_fill && heap_model[right] > heap_model[best]) best = right;
                if (best == pos) break;
                tmp = heap_model[pos];
                heap_model[pos] = heap_model[best];
                heap_model[best] = tmp;
                pos = best;
            end
        end
        res.entry_count = COUNT_OUT_W'(heap_fill);
        return res;
    endfunction

    task automatic report_error(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // caller is at a falling edge; returns at a falling edge
    task automatic send_item(input logic op, input logic [31:0] value);
        int gap;
        heap_result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_tdata <= value;
        s_tuser <= op;
        do @(posedge aclk); while (!s_ready);
        res = heap_apply(op, value);
        pending_results.push_back(res);
        if (op == OP_INSERT) n_insert++;
        else n_extract++;
        if (res.status == STATUS_FULL) n_full++;
        if (res.status == STATUS_EMPTY) n_empty++;
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver: random stalls plus an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 9) < 3) rx_wait = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        heap_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("unexpected result tdata=%h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (m_tdata[31:0] !== want.max_value)
                    report_error($sformatf("max_value got %h want %h",
                                           m_tdata[31:0], want.max_value));
                if (m_tdata[33:32] !== want.status)
                    report_error($sformatf("status got %0d want %0d",
                                           m_tdata[33:32], want.status));
                if (m_tdata[39:34] !== want.entry_count)
                    report_error($sformatf("entry_count got %0d want %0d",
                                           m_tdata[39:34], want.entry_count));
            end
        end
    end

    task automatic test_directed();
        send_item(OP_EXTRACT, 32'hdead_beef);    // extract when empty
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_EXTRACT, 32'hffff_ffff);    // last entry, no sift
        send_item(OP_INSERT, 32'h7fff_ffff);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'hffff_ffff);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_INSERT, 32'h0000_0005);
        send_item(OP_INSERT, 32'h0000_0005);
        send_item(OP_INSERT, 32'h0000_0005);
        send_item(OP_INSERT, 32'h5555_5555);
        send_item(OP_INSERT, 32'haaaa_aaaa);
        repeat (11) send_item(OP_EXTRACT, $urandom);
        wait_for_drain();
    endtask

    task automatic test_full_heap();
        repeat (CAPACITY) send_item(OP_INSERT, 32'($signed($urandom_range(0, 7)) - 4));
        send_item(OP_INSERT, 32'h7fff_ffff);     // insert when full
        send_item(OP_INSERT, 32'h8000_0000);
        repeat (CAPACITY + 1) send_item(OP_EXTRACT, $urandom);
        wait_for_drain();
    endtask

    task automatic test_backpressure();
        @(posedge aclk);
        rx_hold = HOLD_CYCLES;
        @(negedge aclk);
        repeat (20) send_item($urandom_range(0, 3) == 0 ? OP_EXTRACT : OP_INSERT,
                              rand_value());
        wait_for_drain();
    endtask

    task automatic test_random();
        int insert_pct;
        for (int phase = 0; phase < 9; phase++) begin
            case ($urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 50;
                default: insert_pct = 15;
            endcase
            no_idle = (phase % 4 == 3);
            repeat ($urandom_range(30, 45))
                send_item($urandom_range(0, 99) < insert_pct ? OP_INSERT : OP_EXTRACT,
                          rand_value());
            if (phase == 5) wait_for_drain();
        end
        no_idle = 1'b0;
        wait_for_drain();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_full_heap();
        test_backpressure();
        test_random();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        $display("covered %0d inserts, %0d extracts, %0d full and %0d empty rejects",
                 n_insert, n_extract, n_full, n_empty);
        $display("%0d results checked in %0d cycles, %0d mismatches",
                 n_checked, cycle_count, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
